// File: hdl/slr_pkg.sv
// Shared types, constants and register codes for the stereo linear resampler.
package slr_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 15;
    localparam int PHASE_W    = 36;
    localparam int CFG_DATA_W = 36;
    localparam int CFG_IDX_W  = 1;

    // Defaults for the top-level parameters
    localparam int PHASE_FRAC_BITS_DEF = 32;
    localparam int MAX_OUT_PER_IN_DEF  = 8;

    // Queue depths (powers of two)
    localparam int IN_Q_DEPTH  = 2;
    localparam int OUT_Q_DEPTH = 4;
    localparam int OUT_CNT_W   = $clog2(OUT_Q_DEPTH + 1);

    // Register reset values
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 36'h1_0000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 1'b0,
        CFG_BYPASS     = 1'b1
    } t_cfg_idx;

    // Input word: one source frame
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } t_in_word;

    // Result word: one output frame
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       last_of_run;
    } t_out_word;

    // Queued frame, tagged with its handling at accept time
    typedef struct packed {
        t_in_word frame;
        logic     bypass;
    } t_front_word;

    // Write into the result queue
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_out_wr;

endpackage

// File: hdl/slr_front.sv
// Front end: accepts source frames, tags bypass handling, queues them for the back end.
module slr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  slr_pkg::t_in_word    i_in,
    input  logic                 i_bypass,
    output logic                 o_head_valid,
    output slr_pkg::t_front_word o_head,
    input  logic                 i_head_pop
);

    localparam int DEPTH = slr_pkg::IN_Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slr_pkg::t_front_word r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 wr_en, rd_en;

    assign full         = (r_count == CNT_W'(DEPTH));
    assign wr_en        = push && !full;
    assign rd_en        = i_head_pop && o_head_valid;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Storage: classify and write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= '{frame: i_in, bypass: i_bypass};
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("input queue count out of range");

endmodule

// File: hdl/slr_out_queue.sv
// Result queue: holds finished output frames until popped.
module slr_out_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slr_pkg::t_out_wr                  i_wr,
    input  logic                              pop,
    output logic                              empty,
    output slr_pkg::t_out_word                o_out,
    output logic [slr_pkg::OUT_CNT_W-1:0]     o_count
);

    localparam int DEPTH = slr_pkg::OUT_Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = slr_pkg::OUT_CNT_W;

    slr_pkg::t_out_word r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               rd_en;

    assign empty   = (r_count == '0);
    assign rd_en   = pop && !empty;
    assign o_out   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wr_ptr] <= i_wr.word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({i_wr.valid, rd_en})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Credit scheme upstream must never write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.valid |-> (r_count != CNT_W'(DEPTH)))
        else $error("result queue written while full");

endmodule

// File: hdl/slr_back.sv
// Back end: phase sequencer and two-stage interpolation datapath.
module slr_back #(
    parameter int PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF,
    parameter int MAX_OUT_PER_IN  = slr_pkg::MAX_OUT_PER_IN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_head_valid,
    input  slr_pkg::t_front_word                i_head,
    output logic                                o_head_pop,
    input  logic [slr_pkg::PHASE_W-1:0]         i_phase_step,
    input  logic [slr_pkg::OUT_CNT_W-1:0]       i_out_count,
    output slr_pkg::t_out_wr                    o_wr
);

    localparam int PW    = slr_pkg::PHASE_W;
    localparam int SW    = slr_pkg::SAMPLE_W;
    localparam int WW    = slr_pkg::WEIGHT_W;
    localparam int N_W   = $clog2(MAX_OUT_PER_IN + 1);
    localparam int OC_W  = slr_pkg::OUT_CNT_W;
    localparam int P0_W  = SW + WW + 2;   // sample x (weight range up to 2^15)
    localparam int P1_W  = SW + WW + 1;
    localparam int SUM_W = P0_W + 1;
    localparam logic [PW-1:0] ONE_FRAME = PW'(1) << PHASE_FRAC_BITS;

    // Sequencer state
    logic [PW-1:0]        r_phase, n_phase;
    logic signed [SW-1:0] r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic [N_W-1:0]       r_n, n_n;

    // Stage 1: operands
    logic                 r_s1_v, n_s1_v;
    logic signed [SW-1:0] r_s1_a_l, n_s1_a_l, r_s1_a_r, n_s1_a_r;
    logic signed [SW-1:0] r_s1_b_l, n_s1_b_l, r_s1_b_r, n_s1_b_r;
    logic [WW-1:0]        r_s1_w1, n_s1_w1;
    logic                 r_s1_last, n_s1_last;

    // Stage 2: products
    logic                   r_s2_v;
    logic signed [P0_W-1:0] r_p0_l, r_p0_r;
    logic signed [P1_W-1:0] r_p1_l, r_p1_r;
    logic                   r_s2_last;

    logic                   whole, next_whole, room;
    logic [PW-1:0]          next_phase;
    logic [WW:0]            s1_w0;
    logic [OC_W:0]          pending;
    logic signed [SUM_W-1:0] sum_l, sum_r;

    assign whole      = |r_phase[PW-1:PHASE_FRAC_BITS];
    assign next_phase = r_phase + i_phase_step;
    assign next_whole = |next_phase[PW-1:PHASE_FRAC_BITS];
    assign pending    = (OC_W+1)'(i_out_count) + (OC_W+1)'(r_s1_v) + (OC_W+1)'(r_s2_v);
    assign room       = (pending < (OC_W+1)'(slr_pkg::OUT_Q_DEPTH));

    // Sequencer: one output per cycle if the queue has room, then frame close
    always_comb begin
        n_phase    = r_phase;
        n_prev_l   = r_prev_l;
        n_prev_r   = r_prev_r;
        n_n        = r_n;
        n_s1_v     = 1'b0;
        n_s1_a_l   = r_prev_l;
        n_s1_a_r   = r_prev_r;
        n_s1_b_l   = i_head.frame.in_left;
        n_s1_b_r   = i_head.frame.in_right;
        n_s1_w1    = r_phase[PHASE_FRAC_BITS-1 -: WW];
        n_s1_last  = 1'b0;
        o_head_pop = 1'b0;
        if (i_head_valid) begin
            priority if (i_head.bypass) begin
                // pass through: full weight on the current frame itself
                if (room) begin
                    n_s1_v     = 1'b1;
                    n_s1_a_l   = i_head.frame.in_left;
                    n_s1_a_r   = i_head.frame.in_right;
                    n_s1_w1    = '0;
                    n_s1_last  = 1'b1;
                    o_head_pop = 1'b1;
                end
            end else if (whole || (r_n == N_W'(MAX_OUT_PER_IN))) begin
                // close the frame: drop one whole frame, floor at zero
                n_phase    = whole ? (r_phase - ONE_FRAME) : '0;
                n_prev_l   = i_head.frame.in_left;
                n_prev_r   = i_head.frame.in_right;
                n_n        = '0;
                o_head_pop = 1'b1;
            end else if (room) begin
                n_s1_v    = 1'b1;
                n_s1_last = (r_n == N_W'(MAX_OUT_PER_IN - 1)) || next_whole;
                n_phase   = next_phase;
                n_n       = r_n + N_W'(1);
            end else begin
                // result queue has no room: hold the frame
            end
        end
    end

    // Sequencer and valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_n      <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_prev_l <= n_prev_l;
            r_prev_r <= n_prev_r;
            r_n      <= n_n;
            r_s1_v   <= n_s1_v;
            r_s2_v   <= r_s1_v;
        end
    end

    assign s1_w0 = (WW+1)'(1 << WW) - (WW+1)'(r_s1_w1);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (n_s1_v) begin
            r_s1_a_l  <= n_s1_a_l;
            r_s1_a_r  <= n_s1_a_r;
            r_s1_b_l  <= n_s1_b_l;
            r_s1_b_r  <= n_s1_b_r;
            r_s1_w1   <= n_s1_w1;
            r_s1_last <= n_s1_last;
        end
        if (r_s1_v) begin
            r_p0_l    <= r_s1_a_l * $signed({1'b0, s1_w0});
            r_p0_r    <= r_s1_a_r * $signed({1'b0, s1_w0});
            r_p1_l    <= r_s1_b_l * $signed({1'b0, r_s1_w1});
            r_p1_r    <= r_s1_b_r * $signed({1'b0, r_s1_w1});
            r_s2_last <= r_s1_last;
        end
    end

    // Sum and floor by 2^15: the bit slice of the two's complement sum
    assign sum_l = SUM_W'(r_p0_l) + SUM_W'(r_p1_l);
    assign sum_r = SUM_W'(r_p0_r) + SUM_W'(r_p1_r);

    assign o_wr.valid            = r_s2_v;
    assign o_wr.word.out_left    = sum_l[WW +: SW];
    assign o_wr.word.out_right   = sum_r[WW +: SW];
    assign o_wr.word.last_of_run = r_s2_last;

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_W'(MAX_OUT_PER_IN))
        else $error("output run count past its cap");

    a_bypass_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_head_pop && i_head.bypass) |=> ($stable(r_phase) && $stable(r_prev_l)))
        else $error("bypass frame changed interpolation state");

    a_close_resets_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_head_pop && !i_head.bypass) |=> (r_n == '0))
        else $error("run count not cleared at frame close");

    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |=> r_s2_v)
        else $error("interpolation pipe dropped a word");

endmodule

// File: hdl/stereo_linear_resampler_top.sv
// Frames pass the input queue, the operand and product registers, then the result queue.
// The phase sequencer sets the throughput: it gives a frame's outputs (up to MAX_OUT_PER_IN)
// while the result queue has room, then closes the frame; a bypassed frame gives one output.
// Reset is synchronous, active low: queues empty, phase and previous frame zero,
// phase_step 2^32 (one whole frame at the default PHASE_FRAC_BITS), bypass off.
// Top level of the stereo linear resampler.
module stereo_linear_resampler_top #(
    parameter int PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF,
    parameter int MAX_OUT_PER_IN  = slr_pkg::MAX_OUT_PER_IN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  slr_pkg::t_in_word                 i_in,
    output logic                              empty,
    input  logic                              pop,
    output slr_pkg::t_out_word                o_out,
    input  logic                              i_cfg_we,
    input  logic [slr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [slr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    logic [slr_pkg::PHASE_W-1:0]   r_phase_step;
    logic                          r_bypass;
    logic                          head_valid, head_pop;
    slr_pkg::t_front_word          head;
    slr_pkg::t_out_wr              out_wr;
    logic [slr_pkg::OUT_CNT_W-1:0] out_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= slr_pkg::PHASE_STEP_RST;
            r_bypass     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (slr_pkg::t_cfg_idx'(i_cfg_idx))
                slr_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_wdata[slr_pkg::PHASE_W-1:0];
                slr_pkg::CFG_BYPASS:     r_bypass     <= i_cfg_wdata[0];
                default:                 r_bypass     <= r_bypass;
            endcase
        end
    end

    slr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in         (i_in),
        .i_bypass     (r_bypass),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_pop   (head_pop)
    );

    slr_back #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .MAX_OUT_PER_IN  (MAX_OUT_PER_IN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_phase_step (r_phase_step),
        .i_out_count  (out_count),
        .o_wr         (out_wr)
    );

    slr_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .pop     (pop),
        .empty   (empty),
        .o_out   (o_out),
        .o_count (out_count)
    );

endmodule
